[hdl/gtsa_pkg.sv]
// shared constants, widths and codes for the gf2 transvection sequence block
package gtsa_pkg;

    // table depth and vector width
    localparam int MAX_ENTRIES = 16;
    localparam int VECTOR_BITS = 64;

    // table index and walk counter widths
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // item field widths
    localparam int OPCODE_W = 2;
    localparam int SLOT_W   = 4;
    localparam int BIT_W    = 6;
    localparam int VEC_W    = 64;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;
    localparam int WID_W    = 7;

    // packed stream widths
    localparam int S_TDATA_W = SLOT_W + 2 * BIT_W + VEC_W;
    localparam int M_TDATA_W = VEC_W;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd1;

    // reset values of the configuration registers
    localparam logic [LEN_W-1:0] LENGTH_RESET = 5'd0;
    localparam logic [WID_W-1:0] WIDTH_RESET  = 7'd64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_APPLY   = 2'd1,
        OP_INVERSE = 2'd2,
        OP_PASS    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_LOADED   = 2'd0,
        STAT_REJECTED = 2'd1,
        STAT_VECTOR   = 2'd2
    } status_t;

endpackage

[hdl/gf2_transvection_sequence_apply.sv]
// top level: transvection table, sequencer and shared single-flip unit
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+-------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata: slot, target, source, vector; tuser: opcode
//  m_       | out       | m_tvalid/m_tready  | tdata: vector_out; tuser: status
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (length, width)
//
// a load item does no walk: it goes through the run state straight to the output register
// an apply or inverse item does L flips, L the clamped length, then fills the output register;
// the one flip unit reads one table entry per cycle
// s_tready is high only while the sequencer is idle; a finished result sits in the
// output register and a new item may be taken while it waits for m_tready
// aresetn clears control and configuration; the table itself has no reset
module gf2_transvection_sequence_apply (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // from bit 0: entry_slot[3:0], target_bit[9:4], source_bit[15:10], vector_in[79:16]
    input  logic [gtsa_pkg::S_TDATA_W-1:0]     s_tdata,
    // from bit 0: opcode[1:0]
    input  logic [gtsa_pkg::OPCODE_W-1:0]      s_tuser,
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // from bit 0: vector_out[63:0]
    output logic [gtsa_pkg::M_TDATA_W-1:0]     m_tdata,
    // from bit 0: status[1:0]
    output logic [gtsa_pkg::STATUS_W-1:0]      m_tuser,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gtsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gtsa_pkg::CFG_DAT_W-1:0]     cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                          state_reg;
    logic [gtsa_pkg::LEN_W-1:0]      length_reg;
    logic [gtsa_pkg::WID_W-1:0]      width_reg;

    // transvection table, written on good loads only
    logic [gtsa_pkg::BIT_W-1:0]      tgt_mem [gtsa_pkg::MAX_ENTRIES];
    logic [gtsa_pkg::BIT_W-1:0]      src_mem [gtsa_pkg::MAX_ENTRIES];

    // working state of the walk
    logic [gtsa_pkg::VEC_W-1:0]      vec_reg;
    logic [gtsa_pkg::STATUS_W-1:0]   stat_reg;
    logic [gtsa_pkg::IDX_W-1:0]      idx_reg;
    logic [gtsa_pkg::CNT_W-1:0]      remain_reg;
    logic                            reverse_reg;

    // output register
    logic                            m_tvalid_reg;
    logic [gtsa_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic [gtsa_pkg::STATUS_W-1:0]   m_tuser_reg;

    // unpacked input fields
    logic [gtsa_pkg::SLOT_W-1:0]     in_slot;
    logic [gtsa_pkg::BIT_W-1:0]      in_tgt;
    logic [gtsa_pkg::BIT_W-1:0]      in_src;
    logic [gtsa_pkg::VEC_W-1:0]      in_vec;
    gtsa_pkg::opcode_t               in_op;

    logic [gtsa_pkg::WID_W-1:0]      w_eff;
    logic [gtsa_pkg::CNT_W-1:0]      n_eff;
    logic                            load_ok;
    logic                            s_accept;
    logic                            out_free;
    logic                            walk_done;

    // shared flip unit
    logic [gtsa_pkg::BIT_W-1:0]      cur_tgt;
    logic [gtsa_pkg::BIT_W-1:0]      cur_src;
    logic                            flip_hit;
    logic [gtsa_pkg::VEC_W-1:0]      vec_step;

    assign in_slot = s_tdata[gtsa_pkg::SLOT_W-1:0];
    assign in_tgt  = s_tdata[gtsa_pkg::SLOT_W +: gtsa_pkg::BIT_W];
    assign in_src  = s_tdata[gtsa_pkg::SLOT_W + gtsa_pkg::BIT_W +: gtsa_pkg::BIT_W];
    assign in_vec  = s_tdata[gtsa_pkg::SLOT_W + 2 * gtsa_pkg::BIT_W +: gtsa_pkg::VEC_W];
    assign in_op   = gtsa_pkg::opcode_t'(s_tuser);

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    // walk finished and the output register can take the item
    assign walk_done = (state_reg == S_RUN) && (remain_reg == '0) && out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // clamp the registers to the table depth and vector width
    always_comb begin
        if (int'(width_reg) > gtsa_pkg::VECTOR_BITS) begin
            w_eff = gtsa_pkg::WID_W'(gtsa_pkg::VECTOR_BITS);
        end else begin
            w_eff = width_reg;
        end
        if (int'(length_reg) > gtsa_pkg::MAX_ENTRIES) begin
            n_eff = gtsa_pkg::CNT_W'(gtsa_pkg::MAX_ENTRIES);
        end else begin
            n_eff = gtsa_pkg::CNT_W'(length_reg);
        end
    end

    // a load needs two distinct indices below the width and a slot in range
    assign load_ok = (in_tgt != in_src)
                  && ({1'b0, in_tgt} < w_eff)
                  && ({1'b0, in_src} < w_eff)
                  && (int'(in_slot) < gtsa_pkg::MAX_ENTRIES);

    // one conditional flip; stale or degenerate entries leave the vector alone
    always_comb begin
        cur_tgt  = tgt_mem[idx_reg];
        cur_src  = src_mem[idx_reg];
        flip_hit = (cur_tgt != cur_src)
                && ({1'b0, cur_tgt} < w_eff)
                && ({1'b0, cur_src} < w_eff)
                && vec_reg[cur_src];
        vec_step = vec_reg ^ (gtsa_pkg::VEC_W'(flip_hit) << cur_tgt);
    end

    // table writes, no reset
    always_ff @(posedge aclk) begin
        if (s_accept && (in_op == gtsa_pkg::OP_LOAD) && load_ok) begin
            tgt_mem[gtsa_pkg::IDX_W'(in_slot)] <= in_tgt;
            src_mem[gtsa_pkg::IDX_W'(in_slot)] <= in_src;
        end
    end

    // sequencer, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            length_reg   <= gtsa_pkg::LENGTH_RESET;
            width_reg    <= gtsa_pkg::WIDTH_RESET;
            remain_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gtsa_pkg::REG_LENGTH: length_reg <= cfg_data[gtsa_pkg::LEN_W-1:0];
                    gtsa_pkg::REG_WIDTH:  width_reg  <= cfg_data[gtsa_pkg::WID_W-1:0];
                    default: ;
                endcase
            end

            if (walk_done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        state_reg   <= S_RUN;
                        reverse_reg <= (in_op == gtsa_pkg::OP_INVERSE);
                        case (in_op)
                            gtsa_pkg::OP_LOAD: begin
                                vec_reg    <= '0;
                                stat_reg   <= load_ok ? gtsa_pkg::STAT_LOADED
                                                      : gtsa_pkg::STAT_REJECTED;
                                remain_reg <= '0;
                                idx_reg    <= '0;
                            end
                            gtsa_pkg::OP_APPLY: begin
                                vec_reg    <= in_vec;
                                stat_reg   <= gtsa_pkg::STAT_VECTOR;
                                remain_reg <= n_eff;
                                idx_reg    <= '0;
                            end
                            gtsa_pkg::OP_INVERSE: begin
                                vec_reg    <= in_vec;
                                stat_reg   <= gtsa_pkg::STAT_VECTOR;
                                remain_reg <= n_eff;
                                // last entry first; unused when the length is zero
                                idx_reg    <= gtsa_pkg::IDX_W'(n_eff - gtsa_pkg::CNT_W'(1));
                            end
                            default: begin
                                // the pass opcode passes the vector through
                                vec_reg    <= in_vec;
                                stat_reg   <= gtsa_pkg::STAT_VECTOR;
                                remain_reg <= '0;
                                idx_reg    <= '0;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (remain_reg != '0) begin
                        vec_reg    <= vec_step;
                        remain_reg <= remain_reg - gtsa_pkg::CNT_W'(1);
                        idx_reg    <= reverse_reg ? idx_reg - gtsa_pkg::IDX_W'(1)
                                                  : idx_reg + gtsa_pkg::IDX_W'(1);
                    end else if (out_free) begin
                        // hand the finished item to the output register
                        m_tdata_reg  <= vec_reg;
                        m_tuser_reg  <= stat_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a load never starts a walk over the table
    a_load_no_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_op == gtsa_pkg::OP_LOAD)) |=> (state_reg == S_RUN)
            && (remain_reg == '0))
        else $error("load item started a table walk");

    // the walk count never exceeds the table depth
    a_remain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(remain_reg) <= gtsa_pkg::MAX_ENTRIES)
        else $error("walk count beyond table depth");

    // no result is offered while flips are still pending
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_RUN) && (remain_reg != '0) && !m_tvalid_reg) |=> !m_tvalid_reg)
        else $error("result offered before the walk finished");

    // no new item is taken while the sequencer is busy
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN) |-> !s_tready)
        else $error("input ready during a walk");

    // a result carries a defined status code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == gtsa_pkg::STAT_LOADED)
            || (m_tuser == gtsa_pkg::STAT_REJECTED)
            || (m_tuser == gtsa_pkg::STAT_VECTOR))
        else $error("undefined status on result");

endmodule

[verif/gtsa_result_check.sv]
`timescale 1ns / 1ps
// result checker for the gf2 transvection sequence block: mirrors the table, predicts and compares
module gtsa_result_check (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [gtsa_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [gtsa_pkg::OPCODE_W-1:0]  s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [gtsa_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [gtsa_pkg::STATUS_W-1:0]  m_tuser,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [gtsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gtsa_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             results_outstanding
);

    typedef struct packed {
        logic [gtsa_pkg::VEC_W-1:0] vector;
        gtsa_pkg::status_t          status;
    } vec_result_t;

    vec_result_t                results_due [$];
    logic [gtsa_pkg::BIT_W-1:0] flip_bits [gtsa_pkg::MAX_ENTRIES];
    logic [gtsa_pkg::BIT_W-1:0] test_bits [gtsa_pkg::MAX_ENTRIES];
    logic [gtsa_pkg::LEN_W-1:0] length_reg;
    logic [gtsa_pkg::WID_W-1:0] width_reg;

    initial begin
        mismatch_count = 0;
        results_outstanding = 0;
        length_reg = gtsa_pkg::LENGTH_RESET;
        width_reg = gtsa_pkg::WIDTH_RESET;
        for (int k = 0; k < gtsa_pkg::MAX_ENTRIES; k++) begin
            flip_bits[k] = '0;
            test_bits[k] = '0;
        end
    end

    function automatic int live_width();
        return (width_reg > gtsa_pkg::VECTOR_BITS) ? gtsa_pkg::VECTOR_BITS : int'(width_reg);
    endfunction

    // runs the table forwards or backwards; stale and degenerate entries are skipped
    function automatic logic [gtsa_pkg::VEC_W-1:0] walk_transvections(
        input logic [gtsa_pkg::VEC_W-1:0] v, input bit backwards);
        int w;
        int n;
        int idx;
        w = live_width();
        n = (length_reg > gtsa_pkg::MAX_ENTRIES) ? gtsa_pkg::MAX_ENTRIES : int'(length_reg);
        for (int k = 0; k < n; k++) begin
            idx = backwards ? n - 1 - k : k;
            if (flip_bits[idx] != test_bits[idx] && flip_bits[idx] < w && test_bits[idx] < w
                && v[test_bits[idx]])
                v[flip_bits[idx]] = ~v[flip_bits[idx]];
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [gtsa_pkg::VEC_W-1:0] got,
                                   input logic [gtsa_pkg::VEC_W-1:0] want);
        $display("%0t ns mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : watch
        vec_result_t        want;
        vec_result_t        fresh;
        gtsa_pkg::opcode_t  op;
        logic [3:0]         slot;
        logic [5:0]         flip;
        logic [5:0]         test;
        logic [63:0]        vec;
        int                 w;
        if (!aresetn) begin
            length_reg = gtsa_pkg::LENGTH_RESET;
            width_reg = gtsa_pkg::WIDTH_RESET;
            results_due.delete();
        end else begin
            // results leave before new items can add to the store
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with nothing due", m_tdata, '0);
                end else begin
                    want = results_due.pop_front();
                    if (m_tdata !== want.vector)
                        report_mismatch("vector_out", m_tdata, want.vector);
                    if (m_tuser !== want.status)
                        report_mismatch("status", gtsa_pkg::VEC_W'(m_tuser),
                                        gtsa_pkg::VEC_W'(want.status));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gtsa_pkg::REG_LENGTH: length_reg = cfg_data[gtsa_pkg::LEN_W-1:0];
                    gtsa_pkg::REG_WIDTH:  width_reg = cfg_data[gtsa_pkg::WID_W-1:0];
                    default:    ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                op = gtsa_pkg::opcode_t'(s_tuser);
                slot = s_tdata[3:0];
                flip = s_tdata[9:4];
                test = s_tdata[15:10];
                vec = s_tdata[79:16];
                w = live_width();
                fresh.vector = '0;
                fresh.status = gtsa_pkg::STAT_VECTOR;
                case (op)
                    gtsa_pkg::OP_LOAD: begin
                        if (flip == test || flip >= w || test >= w) begin
                            fresh.status = gtsa_pkg::STAT_REJECTED;
                        end else begin
                            flip_bits[slot] = flip;
                            test_bits[slot] = test;
                            fresh.status = gtsa_pkg::STAT_LOADED;
                        end
                    end
                    gtsa_pkg::OP_APPLY:   fresh.vector = walk_transvections(vec, 1'b0);
                    gtsa_pkg::OP_INVERSE: fresh.vector = walk_transvections(vec, 1'b1);
                    gtsa_pkg::OP_PASS:    fresh.vector = vec;
                    default:              fresh.vector = vec;
                endcase
                results_due = {results_due, fresh};
            end
        end
        results_outstanding = results_due.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// stimulus, handshake pacing and verdict for the gf2 transvection sequence block
module tb;

    localparam int HALF_PERIOD     = 10;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 155;
    // an apply walks at most 16 table entries, so this is ample for the block to go quiet
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_CYCLES     = 300;
    // cycles with no handshake on any channel before the run is called hung
    localparam int STALL_LIMIT     = 4000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;

    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // from bit 0: entry_slot[3:0], target_bit[9:4], source_bit[15:10], vector_in[79:16]
    logic [gtsa_pkg::S_TDATA_W-1:0] s_tdata = '0;
    // from bit 0: opcode[1:0]
    logic [gtsa_pkg::OPCODE_W-1:0]  s_tuser = '0;

    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // from bit 0: vector_out[63:0]
    logic [gtsa_pkg::M_TDATA_W-1:0] m_tdata;
    // from bit 0: status[1:0]
    logic [gtsa_pkg::STATUS_W-1:0]  m_tuser;

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [gtsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gtsa_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    int mismatch_count;
    int results_outstanding;
    int idle_count = 0;

    // pacing controls set by the stimulus for the sender and the receiver
    bit tx_no_gap = 1'b0;
    bit rx_no_stall = 1'b0;
    bit rx_hold_req = 1'b0;
    // effective vector width as the sender sees it, used to build well-formed loads
    int cur_width = gtsa_pkg::VECTOR_BITS;

    always #HALF_PERIOD aclk = ~aclk;

    gf2_transvection_sequence_apply uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gtsa_result_check results_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    // watchdog: counts cycles in which no channel moves anything
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver: a random stall before each result, or one long hold-off when asked
    initial begin : receiver
        int stall;
        @(posedge aresetn);
        forever begin
            if (rx_hold_req) begin
                stall = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                stall = rx_no_stall ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // offers one item after a random gap and returns at the falling edge after acceptance;
    // tvalid is left high so a back-to-back item needs no second assignment in the step
    task automatic send_item(input gtsa_pkg::opcode_t op, input logic [3:0] slot,
                             input logic [5:0] flip, input logic [5:0] test,
                             input logic [63:0] vec);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= {vec, test, flip, slot};
        s_tuser <= op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // stop offering and wait until every result is back and the block has gone quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (results_outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [gtsa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gtsa_pkg::CFG_DAT_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // registers are only touched with the block idle
    task automatic configure(input int len, input int wid);
        drain();
        write_reg(gtsa_pkg::REG_LENGTH, gtsa_pkg::CFG_DAT_W'(len));
        write_reg(gtsa_pkg::REG_WIDTH, gtsa_pkg::CFG_DAT_W'(wid));
        cfg_valid <= 1'b0;
        cur_width = ((wid % 128) > gtsa_pkg::VECTOR_BITS) ? gtsa_pkg::VECTOR_BITS : (wid % 128);
    endtask

    function automatic logic [63:0] random_vector();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0:       v = '1;
            1:       v = '0;
            2:       v = 64'd1 << $urandom_range(0, 63);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // mostly well-formed loads, applies and inverses, a few passes; some loads are plain noise to hit rejection
    task automatic random_item();
        int                 r;
        gtsa_pkg::opcode_t  op;
        logic [3:0]         slot;
        logic [5:0]         flip;
        logic [5:0]         test;
        r = $urandom_range(0, 99);
        slot = 4'($urandom);
        flip = 6'($urandom);
        test = 6'($urandom);
        if (r < 35) begin
            op = gtsa_pkg::OP_LOAD;
            if (r < 29 && cur_width >= 2) begin
                flip = 6'($urandom_range(0, cur_width - 1));
                test = 6'($urandom_range(0, cur_width - 2));
                if (test >= flip)
                    test = test + 6'd1;
            end
        end else if (r < 65) begin
            op = gtsa_pkg::OP_APPLY;
        end else if (r < 92) begin
            op = gtsa_pkg::OP_INVERSE;
        end else begin
            op = gtsa_pkg::OP_PASS;
        end
        send_item(op, slot, flip, test, random_vector());
    endtask

    initial begin : stimulus
        int          len_set [6];
        int          wid_set [6];
        int          len;
        int          wid;
        int          mode;
        logic [5:0]  flip;
        logic [5:0]  test;

        // fixed settings first: both extremes of each register and the clamped values
        len_set = '{16, 0, 31, 1, 16, 17};
        wid_set = '{64, 2, 127, 1, 0, 33};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset length is zero, so applies before the table is filled read no entries
        send_item(gtsa_pkg::OP_APPLY, 4'd0, 6'd0, 6'd0, '1);
        send_item(gtsa_pkg::OP_INVERSE, 4'd0, 6'd0, 6'd0, 64'h8000_0000_0000_0001);
        send_item(gtsa_pkg::OP_PASS, 4'hF, 6'h3F, 6'h3F, random_vector());

        // fill every slot with a valid entry so no later walk meets an unwritten one
        send_item(gtsa_pkg::OP_LOAD, 4'd0, 6'd63, 6'd0, '0);
        send_item(gtsa_pkg::OP_LOAD, 4'd1, 6'd0, 6'd63, '1);
        for (int k = 2; k < gtsa_pkg::MAX_ENTRIES; k++) begin
            flip = 6'($urandom_range(0, 63));
            test = 6'($urandom_range(0, 62));
            if (test >= flip)
                test = test + 6'd1;
            send_item(gtsa_pkg::OP_LOAD, 4'(k), flip, test, random_vector());
        end
        // target equal to source is refused and leaves the slot alone
        send_item(gtsa_pkg::OP_LOAD, 4'd15, 6'd63, 6'd63, '1);

        // full table, full width
        configure(16, 64);
        send_item(gtsa_pkg::OP_APPLY, 4'd0, 6'd0, 6'd0, '1);
        send_item(gtsa_pkg::OP_APPLY, 4'd0, 6'd0, 6'd0, '0);
        send_item(gtsa_pkg::OP_INVERSE, 4'd0, 6'd0, 6'd0, '1);
        send_item(gtsa_pkg::OP_INVERSE, 4'd0, 6'd0, 6'd0, 64'd1);
        send_item(gtsa_pkg::OP_APPLY, 4'd0, 6'd0, 6'd0, random_vector());

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 6) begin
                len = len_set[ph];
                wid = wid_set[ph];
                mode = ph % 4;
            end else begin
                len = $urandom_range(0, 31);
                wid = $urandom_range(0, 127);
                mode = $urandom_range(0, 3);
            end
            configure(len, wid);
            // pacing per phase: both sides idling, one side flat out, or both flat out
            tx_no_gap = (mode == 1 || mode == 3);
            rx_no_stall = (mode == 2 || mode == 3);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // long receiver hold-off while the sender keeps pushing
                if (ph == 0 && i == 20)
                    rx_hold_req = 1'b1;
                // sender waits for every result before going on
                if (ph == 2 && i == 50)
                    drain();
                random_item();
            end
        end

        drain();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
